/* hdl/smcf_pkg.sv */
// shared types and constants for the shape midline crossing finder
`default_nettype none

package smcf_pkg;

	// fixed field widths
	localparam int PIX_W      = 8;
	localparam int OUT_W      = 8;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST    = 9'd256;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST   = 9'd256;
	localparam logic [PIX_W-1:0]      DARK_THRESHOLD_RST = 8'd127;

	// result kinds
	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] frame_width;
		logic [CFG_DATA_W-1:0] frame_height;
		logic [PIX_W-1:0]      dark_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_DRAIN,
		ST_WALK,
		ST_FLUSH,
		ST_REPORT
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sweep;
		logic search;
		logic hit_clear;
		logic report;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_end;
		logic frame_end;
		logic out_free;
		logic sweep_last;
		logic walk_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hdl/smcf_dpath.sv */
// datapath: pixel tracking, column and row stores, column walk, result register
`default_nettype none

module smcf_dpath import smcf_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	input  wire logic [PIX_W-1:0] pixel,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  kind,
	output logic [OUT_W-1:0]      index,
	output logic [OUT_W-1:0]      position,
	output logic                  found,
	output logic                  last
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int BIGW  = (CW > RW) ? CW : RW;
	localparam int CMP_W = ((BIGW > CFG_DATA_W) ? BIGW : CFG_DATA_W) + 1;

	// row tracking state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] row_first_q;
	logic [CW-1:0] row_last_q;
	logic          row_any_q;

	// column and row stores
	logic          any_mem   [MAX_WIDTH];
	logic [RW-1:0] first_mem [MAX_WIDTH];
	logic [RW-1:0] last_mem  [MAX_WIDTH];
	logic [CW:0]   mid_mem   [MAX_HEIGHT];

	// pixel write-back stage
	logic          pv_s1;
	logic [CW-1:0] x_s1;
	logic [RW-1:0] y_s1;
	logic          fg_s1;
	logic          col_any_s1;
	logic          fwd_v_q;
	logic [CW-1:0] fwd_x_q;
	logic          any_eff;

	// sweep counter and walk pipeline
	logic [CW-1:0] sweep_q;
	logic          va_s1;
	logic [CW-1:0] wcol_s1;
	logic [RW-1:0] first_s1;
	logic [RW-1:0] last_s1;
	logic [RW:0]   ysum;
	logic [RW-1:0] ym;
	logic          vb_s2;
	logic [CW-1:0] wcol_s2;
	logic [RW-1:0] ym_s2;
	logic [CW:0]   mid_s2;
	logic          match;
	logic          hit_q;
	logic [CW-1:0] hx_q;
	logic [RW-1:0] hy_q;

	// output register
	logic             out_valid_q;
	logic             kind_q;
	logic [OUT_W-1:0] index_q;
	logic [OUT_W-1:0] position_q;
	logic             found_q;
	logic             last_q;

	// effective frame size and row/frame end detection
	logic [CMP_W-1:0] w_raw, h_raw, w_eff, h_eff;
	logic             fg;
	logic [CW-1:0]    first_n, last_n;
	logic             any_n;
	logic [CW:0]      msum;
	logic [CW-1:0]    mid;
	logic             row_end, frame_end;
	logic             load_row;

	always_comb begin
		w_raw = CMP_W'(cfg.frame_width);
		h_raw = CMP_W'(cfg.frame_height);
		if (cfg.frame_width == '0)
			w_eff = CMP_W'(1);
		else if (w_raw > CMP_W'(MAX_WIDTH))
			w_eff = CMP_W'(MAX_WIDTH);
		else
			w_eff = w_raw;
		if (cfg.frame_height == '0)
			h_eff = CMP_W'(1);
		else if (h_raw > CMP_W'(MAX_HEIGHT))
			h_eff = CMP_W'(MAX_HEIGHT);
		else
			h_eff = h_raw;
		row_end   = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
		frame_end = row_end && ((CMP_W'(row_q) + CMP_W'(1)) >= h_eff);
	end

	// span of the current row including this pixel
	always_comb begin
		fg      = pixel <= cfg.dark_threshold;
		first_n = (fg && !row_any_q) ? col_q : row_first_q;
		last_n  = fg ? col_q : row_last_q;
		any_n   = row_any_q | fg;
		msum    = (CW+1)'(first_n) + (CW+1)'(last_n);
		mid     = msum[CW:1];
	end

	assign load_row = cmd.accept && row_end;

	// counters and row span registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			row_first_q <= '0;
			row_last_q  <= '0;
			row_any_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (row_end) begin
				col_q       <= '0;
				row_first_q <= '0;
				row_last_q  <= '0;
				row_any_q   <= 1'b0;
				row_q       <= frame_end ? '0 : row_q + RW'(1);
			end else begin
				col_q       <= col_q + CW'(1);
				row_first_q <= first_n;
				row_last_q  <= last_n;
				row_any_q   <= any_n;
			end
		end
	end

	// row midpoint store
	always_ff @(posedge clk) begin
		if (load_row)
			mid_mem[row_q] <= {any_n, mid};
	end

	always_ff @(posedge clk) begin
		mid_s2 <= mid_mem[ym];
	end

	// pixel stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1   <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			pv_s1   <= cmd.accept;
			fwd_v_q <= pv_s1 && fg_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= col_q;
		y_s1    <= row_q;
		fg_s1   <= fg;
		fwd_x_q <= x_s1;
	end

	// column seen flag, forwarded from the previous write to the same column
	assign any_eff = col_any_s1 || (fwd_v_q && (fwd_x_q == x_s1));

	// column flag store: cleared by sweep, set by foreground pixels
	always_ff @(posedge clk) begin
		if (cmd.sweep)
			any_mem[sweep_q] <= 1'b0;
		else if (pv_s1 && fg_s1)
			any_mem[x_s1] <= 1'b1;
		col_any_s1 <= any_mem[cmd.sweep ? sweep_q : col_q];
	end

	// column first and last foreground rows
	always_ff @(posedge clk) begin
		if (pv_s1 && fg_s1 && !any_eff)
			first_mem[x_s1] <= y_s1;
		if (pv_s1 && fg_s1)
			last_mem[x_s1] <= y_s1;
		first_s1 <= first_mem[sweep_q];
		last_s1  <= last_mem[sweep_q];
	end

	// sweep counter over all columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_q <= '0;
		else if (cmd.sweep)
			sweep_q <= sts.sweep_last ? '0 : sweep_q + CW'(1);
	end

	// walk pipeline: column read, then midpoint lookup, then compare
	always_comb begin
		ysum  = (RW+1)'(first_s1) + (RW+1)'(last_s1);
		ym    = ysum[RW:1];
		match = vb_s2 && mid_s2[CW] && (mid_s2[CW-1:0] == wcol_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1 <= 1'b0;
			vb_s2 <= 1'b0;
		end else begin
			va_s1 <= cmd.search;
			vb_s2 <= va_s1 && col_any_s1;
		end
	end

	always_ff @(posedge clk) begin
		wcol_s1 <= sweep_q;
		wcol_s2 <= wcol_s1;
		ym_s2   <= ym;
	end

	// first crossing of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_q <= 1'b0;
		else if (cmd.hit_clear)
			hit_q <= 1'b0;
		else if (match && !hit_q)
			hit_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (match && !hit_q) begin
			hx_q <= wcol_s2;
			hy_q <= ym_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_row || cmd.report)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_row) begin
			kind_q     <= KIND_ROW;
			index_q    <= OUT_W'(row_q);
			position_q <= any_n ? OUT_W'(mid) : '0;
			found_q    <= any_n;
			last_q     <= !frame_end;
		end else if (cmd.report) begin
			kind_q     <= KIND_FRAME;
			index_q    <= hit_q ? OUT_W'(hx_q) : '0;
			position_q <= hit_q ? OUT_W'(hy_q) : '0;
			found_q    <= hit_q;
			last_q     <= 1'b1;
		end
	end

	// status to the controller
	always_comb begin
		sts.row_end    = row_end;
		sts.frame_end  = frame_end;
		sts.out_free   = !out_valid_q || out_ready;
		sts.sweep_last = sweep_q == CW'(MAX_WIDTH - 1);
		sts.walk_busy  = va_s1 || vb_s2;
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign index     = index_q;
	assign position  = position_q;
	assign found     = found_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* hdl/smcf_ctrl.sv */
// controller: run, column walk and clearing sequence
`default_nettype none

module smcf_ctrl import smcf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	fsm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				// a row end needs room in the result register
				in_ready   = !sts.row_end || sts.out_free;
				cmd.accept = in_valid && in_ready;
				if (cmd.accept && sts.frame_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last pixel lands in the column stores
				cmd.hit_clear = 1'b1;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				cmd.sweep  = 1'b1;
				cmd.search = 1'b1;
				if (sts.sweep_last)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!sts.walk_busy)
					state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (sts.out_free) begin
					cmd.report = 1'b1;
					state_d    = ST_RUN;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

`ifndef SYNTH
	a_row_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.row_end) |-> sts.out_free)
		else $error("row result would overwrite a pending result");

	a_frame_end_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.frame_end) |=> (state_q == ST_DRAIN && !in_ready))
		else $error("input not stopped after frame end");

	a_report_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> (sts.out_free && !sts.walk_busy))
		else $error("crossing reported before walk finished");

	a_flush_to_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && !sts.walk_busy) |=> state_q == ST_REPORT)
		else $error("flush did not move on to report");
`endif

endmodule

`default_nettype wire

/* hdl/shape_midline_crossing_finder_core.sv */
// top level: configuration registers, controller and datapath
`default_nettype none

// Takes one 8-bit pixel per cycle in raster order while in_ready is high. The
// last pixel of each row yields a row midpoint result; the last pixel of a
// frame yields that row's result and then the frame crossing result. After the
// last pixel of a frame the input is held off while that pixel reaches the
// column stores, while the walk steps through every column over the single
// read port of the column stores, while the walk pipeline drains, including
// its compare stage when the last column holds foreground, and while the
// crossing result is loaded, which also waits while the result register is
// full and not being taken. A row-end pixel also waits while the result
// register is full and not being taken. After reset the column flags are
// cleared in a pass over all MAX_WIDTH columns before the first pixel is taken;
// configuration writes are taken at any time.
module shape_midline_crossing_finder_core import smcf_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      pixel,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       kind,
	output logic [OUT_W-1:0]           index,
	output logic [OUT_W-1:0]           position,
	output logic                       found,
	output logic                       last
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= FRAME_WIDTH_RST;
			cfg_q.frame_height   <= FRAME_HEIGHT_RST;
			cfg_q.dark_threshold <= DARK_THRESHOLD_RST;
		end else if (cfg_en) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data;
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data;
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	smcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smcf_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.pixel     (pixel),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.kind      (kind),
		.index     (index),
		.position  (position),
		.found     (found),
		.last      (last)
	);

endmodule

`default_nettype wire
